>>> sv/mwc_pkg.sv
// Shared constants, codes and types of the modular walk counter.
package mwc_pkg;

   localparam int DEF_MAX_NODES  = 256;
   localparam int DEF_MAX_EDGES  = 8192;
   localparam int COUNT_W        = 30;
   localparam int NODE_W         = 8;
   localparam int EDGE_W         = 2 * NODE_W;
   localparam int STATUS_W       = 2;
   localparam int WALK_LEN_W     = 16;
   localparam int NODE_COUNT_W   = 9;
   localparam int CSR_DATA_W     = 16;
   localparam int DEF_NODE_COUNT = 256;

   localparam logic [COUNT_W-1:0] WALK_MOD = 30'd1000000007;

   // status bit positions
   localparam int ERR_EDGE_FULL = 0;
   localparam int ERR_BAD_NODE  = 1;

   typedef enum logic [1:0] {
      CMD_ADD_EDGE    = 2'd0,
      CMD_MARK_ACCEPT = 2'd1,
      CMD_RUN         = 2'd2,
      CMD_CLEAR       = 2'd3
   } cmd_type;

   typedef enum logic {
      REG_WALK_LENGTH = 1'b0,
      REG_NODE_COUNT  = 1'b1
   } reg_index_type;

   typedef enum logic [3:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_INIT,
      ST_ZERO,
      ST_EDGE_RD,
      ST_EDGE_OP,
      ST_EDGE_WR,
      ST_SUM_RD,
      ST_SUM_ADD,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic edge_we;
      logic accept_we;
      logic accept_wdata;
      logic row_we;
      logic row_wr_next;
      logic row_wr_sum;
      logic row_wr_one;
      logic parity;
      logic sum_phase;
      logic sum_clr;
      logic sum_en;
   } store_ctrl_type;

endpackage

>>> sv/mwc_if.sv
// Channel interfaces of the modular walk counter: request, response and register write.
interface mwc_req_if;
   import mwc_pkg::*;
   logic              valid;
   logic              ready;
   logic [1:0]        cmd;
   logic [NODE_W-1:0] target_node;
   logic [NODE_W-1:0] source_node;
   modport source (output valid, cmd, target_node, source_node, input ready);
   modport sink (input valid, cmd, target_node, source_node, output ready);
endinterface

interface mwc_rsp_if;
   import mwc_pkg::*;
   logic                valid;
   logic                ready;
   logic [COUNT_W-1:0]  walk_count;
   logic [STATUS_W-1:0] status;
   modport source (output valid, walk_count, status, input ready);
   modport sink (input valid, walk_count, status, output ready);
endinterface

interface mwc_csr_if;
   import mwc_pkg::*;
   logic                  valid;
   logic                  ready;
   logic                  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

>>> sv/mwc_mod_add.sv
// Shared adder modulo 1000000007 for operands already below the modulus.
module mwc_mod_add (
   input  logic [mwc_pkg::COUNT_W-1:0] op_a,
   input  logic [mwc_pkg::COUNT_W-1:0] op_b,
   output logic [mwc_pkg::COUNT_W-1:0] sum
);
   import mwc_pkg::*;

   logic [COUNT_W:0] raw;
   logic [COUNT_W:0] wrapped;

   assign raw     = {1'b0, op_a} + {1'b0, op_b};
   assign wrapped = raw - {1'b0, WALK_MOD};
   assign sum     = (raw >= {1'b0, WALK_MOD}) ? wrapped[COUNT_W-1:0] : raw[COUNT_W-1:0];

endmodule

>>> sv/mwc_store.sv
// Edge store, accept flags and the two ping-pong count rows.
module mwc_store #(
   parameter int MAX_NODES = mwc_pkg::DEF_MAX_NODES,
   parameter int MAX_EDGES = mwc_pkg::DEF_MAX_EDGES,
   localparam int NAW = $clog2(MAX_NODES),
   localparam int EAW = $clog2(MAX_EDGES)
) (
   input  logic                          clock,
   input  mwc_pkg::store_ctrl_type       ctl,
   input  logic [EAW-1:0]                edge_waddr,
   input  logic [mwc_pkg::EDGE_W-1:0]    edge_wdata,
   input  logic [EAW-1:0]                edge_raddr,
   output logic [mwc_pkg::EDGE_W-1:0]    edge_rdata,
   input  logic [NAW-1:0]                accept_addr,
   output logic                          accept_rdata,
   input  logic [NAW-1:0]                prev_raddr,
   input  logic [NAW-1:0]                next_raddr,
   input  logic [NAW-1:0]                row_waddr,
   input  logic [mwc_pkg::COUNT_W-1:0]   row_wdata,
   output logic [mwc_pkg::COUNT_W-1:0]   prev_rdata,
   output logic [mwc_pkg::COUNT_W-1:0]   next_rdata
);
   import mwc_pkg::*;

   logic [EDGE_W-1:0]  edge_mem [MAX_EDGES];
   logic [EDGE_W-1:0]  edge_rd_ff;
   logic               accept_mem [MAX_NODES];
   logic               accept_rd_ff;
   logic [COUNT_W-1:0] even_mem [MAX_NODES];
   logic [COUNT_W-1:0] odd_mem [MAX_NODES];
   logic [COUNT_W-1:0] even_rd_ff;
   logic [COUNT_W-1:0] odd_rd_ff;
   logic [NAW-1:0]     even_raddr;
   logic [NAW-1:0]     odd_raddr;
   logic               wr_odd;

   // parity low: even row holds the previous step, odd row the next one
   assign wr_odd     = ctl.row_wr_next ? ~ctl.parity : ctl.parity;
   assign even_raddr = ctl.parity ? next_raddr : prev_raddr;
   assign odd_raddr  = ctl.parity ? prev_raddr : next_raddr;

   always_ff @(posedge clock) begin
      if (ctl.edge_we) begin
         edge_mem[edge_waddr] <= edge_wdata;
      end
      edge_rd_ff <= edge_mem[edge_raddr];
   end

   always_ff @(posedge clock) begin
      if (ctl.accept_we) begin
         accept_mem[accept_addr] <= ctl.accept_wdata;
      end
      accept_rd_ff <= accept_mem[accept_addr];
   end

   always_ff @(posedge clock) begin
      if (ctl.row_we && !wr_odd) begin
         even_mem[row_waddr] <= row_wdata;
      end
      even_rd_ff <= even_mem[even_raddr];
   end

   always_ff @(posedge clock) begin
      if (ctl.row_we && wr_odd) begin
         odd_mem[row_waddr] <= row_wdata;
      end
      odd_rd_ff <= odd_mem[odd_raddr];
   end

   assign edge_rdata   = edge_rd_ff;
   assign accept_rdata = accept_rd_ff;
   assign prev_rdata   = ctl.parity ? odd_rd_ff : even_rd_ff;
   assign next_rdata   = ctl.parity ? even_rd_ff : odd_rd_ff;

endmodule

>>> sv/mwc_ctrl.sv
// Sequencer: request decode, edge and step counters, error flags and store control.
module mwc_ctrl #(
   parameter int MAX_NODES = mwc_pkg::DEF_MAX_NODES,
   parameter int MAX_EDGES = mwc_pkg::DEF_MAX_EDGES,
   localparam int NAW = $clog2(MAX_NODES),
   localparam int EAW = $clog2(MAX_EDGES)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic [1:0]                        req_cmd,
   input  logic [mwc_pkg::NODE_W-1:0]        req_target,
   input  logic [mwc_pkg::NODE_W-1:0]        req_source,
   output logic                              req_ready,
   input  logic [mwc_pkg::WALK_LEN_W-1:0]    walk_length,
   input  logic [mwc_pkg::NODE_COUNT_W-1:0]  node_count,
   input  logic [mwc_pkg::EDGE_W-1:0]        edge_rdata,
   input  logic                              rsp_free,
   output mwc_pkg::store_ctrl_type           ctl,
   output logic [EAW-1:0]                    edge_waddr,
   output logic [EAW-1:0]                    edge_raddr,
   output logic [NAW-1:0]                    accept_addr,
   output logic [NAW-1:0]                    prev_raddr,
   output logic [NAW-1:0]                    next_raddr,
   output logic [NAW-1:0]                    row_waddr,
   output logic [mwc_pkg::STATUS_W-1:0]      status,
   output logic                              done
);
   import mwc_pkg::*;

   localparam int LW  = $clog2(MAX_NODES + 1);
   localparam int CW  = (LW > NODE_COUNT_W) ? LW : NODE_COUNT_W;
   localparam int ETW = $clog2(MAX_EDGES + 1);

   state_type             state_ff, state_in;
   logic [LW-1:0]         node_idx_ff, node_idx_in;
   logic [ETW-1:0]        edge_idx_ff, edge_idx_in;
   logic [ETW-1:0]        edge_total_ff, edge_total_in;
   logic [WALK_LEN_W-1:0] step_ff, step_in;
   logic                  parity_ff, parity_in;
   logic [STATUS_W-1:0]   error_ff, error_in;

   cmd_type        cmd;
   logic [CW-1:0]  nc;
   logic [CW-1:0]  live;
   logic [CW-1:0]  req_tgt_cw;
   logic [CW-1:0]  req_src_cw;
   logic [CW-1:0]  edge_dst_cw;
   logic [CW-1:0]  edge_src_cw;
   logic [CW-1:0]  node_idx_cw;
   logic [NAW-1:0] node_addr;
   logic           req_fire;
   logic           mark_ok;
   logic           req_nodes_ok;
   logic           edge_ok;
   logic           edge_full;
   logic           node_last;
   logic           sweep_last;
   logic           edge_last;
   logic           step_last;
   logic           no_steps;
   logic           no_edges;
   logic           step_end;

   // node count 0 acts as 1, anything above the store depth as the depth
   always_comb begin
      nc = CW'(node_count);
      if (nc == '0) begin
         live = CW'(1);
      end else if (nc > CW'(MAX_NODES)) begin
         live = CW'(MAX_NODES);
      end else begin
         live = nc;
      end
   end

   assign cmd          = cmd_type'(req_cmd);
   assign req_fire     = req_valid && req_ready;
   assign req_tgt_cw   = CW'(req_target);
   assign req_src_cw   = CW'(req_source);
   assign mark_ok      = req_tgt_cw < live;
   assign req_nodes_ok = mark_ok && (req_src_cw < live);
   assign edge_dst_cw  = CW'(edge_rdata[EDGE_W-1:NODE_W]);
   assign edge_src_cw  = CW'(edge_rdata[NODE_W-1:0]);
   assign edge_ok      = (edge_dst_cw < live) && (edge_src_cw < live);
   assign node_idx_cw  = CW'(node_idx_ff);
   assign node_addr    = node_idx_ff[NAW-1:0];
   assign node_last    = (node_idx_cw + CW'(1)) == live;
   assign sweep_last   = node_idx_ff == LW'(MAX_NODES - 1);
   assign edge_last    = (edge_idx_ff + ETW'(1)) == edge_total_ff;
   assign step_last    = (step_ff + WALK_LEN_W'(1)) == walk_length;
   assign no_steps     = walk_length == '0;
   assign no_edges     = edge_total_ff == '0;
   assign edge_full    = edge_total_ff == ETW'(MAX_EDGES);
   assign step_end     = ((state_ff == ST_ZERO) && node_last && no_edges) ||
                         ((state_ff == ST_EDGE_WR) && edge_last);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_SWEEP: begin
            if (sweep_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_fire) begin
               case (cmd)
                  CMD_RUN:   state_in = ST_INIT;
                  CMD_CLEAR: state_in = ST_SWEEP;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_INIT: begin
            if (node_last) state_in = no_steps ? ST_SUM_RD : ST_ZERO;
         end
         ST_ZERO: begin
            if (node_last) begin
               if (!no_edges) begin
                  state_in = ST_EDGE_RD;
               end else begin
                  state_in = step_last ? ST_SUM_RD : ST_ZERO;
               end
            end
         end
         ST_EDGE_RD: state_in = ST_EDGE_OP;
         ST_EDGE_OP: state_in = ST_EDGE_WR;
         ST_EDGE_WR: begin
            if (edge_last) begin
               state_in = step_last ? ST_SUM_RD : ST_ZERO;
            end else begin
               state_in = ST_EDGE_RD;
            end
         end
         ST_SUM_RD:  state_in = ST_SUM_ADD;
         // read the next node's count and flag before adding it
         ST_SUM_ADD: begin
            state_in = node_last ? ST_DONE : ST_SUM_RD;
         end
         ST_DONE: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_SWEEP;
      endcase
   end

   // counters, edge fill and sticky error flags
   always_comb begin
      node_idx_in   = node_idx_ff;
      edge_idx_in   = edge_idx_ff;
      edge_total_in = edge_total_ff;
      step_in       = step_ff;
      parity_in     = parity_ff;
      error_in      = error_ff;
      case (state_ff)
         ST_SWEEP: begin
            node_idx_in = sweep_last ? '0 : node_idx_ff + LW'(1);
         end
         ST_IDLE: begin
            if (req_fire) begin
               case (cmd)
                  CMD_ADD_EDGE: begin
                     if (!req_nodes_ok) begin
                        error_in[ERR_BAD_NODE] = 1'b1;
                     end else if (edge_full) begin
                        error_in[ERR_EDGE_FULL] = 1'b1;
                     end else begin
                        edge_total_in = edge_total_ff + ETW'(1);
                     end
                  end
                  CMD_MARK_ACCEPT: begin
                     if (!mark_ok) error_in[ERR_BAD_NODE] = 1'b1;
                  end
                  CMD_RUN: begin
                     node_idx_in = '0;
                     step_in     = '0;
                     parity_in   = 1'b0;
                  end
                  default: begin
                     node_idx_in   = '0;
                     edge_total_in = '0;
                  end
               endcase
            end
         end
         ST_INIT, ST_ZERO, ST_SUM_ADD: begin
            node_idx_in = node_last ? '0 : node_idx_ff + LW'(1);
            if (state_ff == ST_ZERO) edge_idx_in = '0;
         end
         ST_EDGE_WR: begin
            edge_idx_in = edge_idx_ff + ETW'(1);
         end
         default: begin
         end
      endcase
      if (step_end) begin
         step_in   = step_ff + WALK_LEN_W'(1);
         parity_in = ~parity_ff;
      end
   end

   // outputs
   always_comb begin
      ctl          = '0;
      ctl.parity   = parity_ff;
      req_ready    = 1'b0;
      done         = 1'b0;
      accept_addr  = node_addr;
      row_waddr    = node_addr;
      prev_raddr   = edge_src_cw[NAW-1:0];
      next_raddr   = edge_dst_cw[NAW-1:0];
      case (state_ff)
         ST_SWEEP: begin
            ctl.accept_we    = 1'b1;
            ctl.accept_wdata = 1'b0;
         end
         ST_IDLE: begin
            req_ready   = 1'b1;
            accept_addr = req_tgt_cw[NAW-1:0];
            ctl.edge_we = req_fire && (cmd == CMD_ADD_EDGE) && req_nodes_ok && !edge_full;
            ctl.accept_we    = req_fire && (cmd == CMD_MARK_ACCEPT) && mark_ok;
            ctl.accept_wdata = 1'b1;
         end
         ST_INIT: begin
            ctl.row_we     = 1'b1;
            ctl.row_wr_one = node_idx_ff == '0;
            ctl.sum_clr    = 1'b1;
         end
         ST_ZERO: begin
            ctl.row_we      = 1'b1;
            ctl.row_wr_next = 1'b1;
         end
         ST_EDGE_WR: begin
            // skip edges that touch a node at or above the current node count
            ctl.row_we      = edge_ok;
            ctl.row_wr_next = 1'b1;
            ctl.row_wr_sum  = 1'b1;
            row_waddr       = edge_dst_cw[NAW-1:0];
         end
         ST_SUM_RD: begin
            prev_raddr = node_addr;
         end
         ST_SUM_ADD: begin
            ctl.sum_phase = 1'b1;
            ctl.sum_en    = 1'b1;
         end
         ST_DONE: begin
            done = rsp_free;
         end
         default: begin
         end
      endcase
   end

   assign edge_waddr = edge_total_ff[EAW-1:0];
   assign edge_raddr = edge_idx_ff[EAW-1:0];
   assign status     = error_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_SWEEP;
         node_idx_ff   <= '0;
         edge_idx_ff   <= '0;
         edge_total_ff <= '0;
         step_ff       <= '0;
         parity_ff     <= 1'b0;
         error_ff      <= '0;
      end else begin
         state_ff      <= state_in;
         node_idx_ff   <= node_idx_in;
         edge_idx_ff   <= edge_idx_in;
         edge_total_ff <= edge_total_in;
         step_ff       <= step_in;
         parity_ff     <= parity_in;
         error_ff      <= error_in;
      end
   end

endmodule

>>> sv/modular_walk_counter.sv
// Top level of the modular walk counter: registers, response stage and unit wiring.
//
//   channel  port    dir  payload
//   request  req_if  in   cmd, target_node, source_node
//   result   rsp_if  out  walk_count, status
//   regs     csr_if  in   index (0 walk_length, 1 node_count), data
//
// Add-edge and mark items are handled in the idle state; a clear item sweeps the
// accept store with req ready low. A run of walk length L starts the count rows,
// then per step zeroes the next row and adds each stored edge through the single
// modular adder (read edge, read rows, write back per edge), then sums accepted rows.
// After reset the accept store is swept with req ready low.
// The result sits in an output register; loads are taken while it waits, and a
// run that finishes before it is taken holds in its last state.
module modular_walk_counter #(
   parameter int MAX_NODES = mwc_pkg::DEF_MAX_NODES,
   parameter int MAX_EDGES = mwc_pkg::DEF_MAX_EDGES
) (
   input  logic         clock,
   input  logic         reset,
   mwc_req_if.sink      req_if,
   mwc_rsp_if.source    rsp_if,
   mwc_csr_if.sink      csr_if
);
   import mwc_pkg::*;

   localparam int NAW = $clog2(MAX_NODES);
   localparam int EAW = $clog2(MAX_EDGES);

   logic [WALK_LEN_W-1:0]   walk_length_ff;
   logic [NODE_COUNT_W-1:0] node_count_ff;
   logic [COUNT_W-1:0]      sum_ff;
   logic                    rsp_valid_ff;
   logic [COUNT_W-1:0]      rsp_count_ff;
   logic [STATUS_W-1:0]     rsp_status_ff;

   store_ctrl_type          ctl;
   logic                    csr_fire;
   logic                    rsp_free;
   logic                    done;
   logic [STATUS_W-1:0]     status;
   logic [EAW-1:0]          edge_waddr;
   logic [EAW-1:0]          edge_raddr;
   logic [EDGE_W-1:0]       edge_rdata;
   logic [NAW-1:0]          accept_addr;
   logic                    accept_rdata;
   logic [NAW-1:0]          prev_raddr;
   logic [NAW-1:0]          next_raddr;
   logic [NAW-1:0]          row_waddr;
   logic [COUNT_W-1:0]      row_wdata;
   logic [COUNT_W-1:0]      prev_rdata;
   logic [COUNT_W-1:0]      next_rdata;
   logic [COUNT_W-1:0]      add_a;
   logic [COUNT_W-1:0]      add_b;
   logic [COUNT_W-1:0]      add_sum;

   assign csr_if.ready = 1'b1;
   assign csr_fire     = csr_if.valid && csr_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         walk_length_ff <= '0;
         node_count_ff  <= NODE_COUNT_W'(DEF_NODE_COUNT);
      end else if (csr_fire) begin
         case (reg_index_type'(csr_if.index))
            REG_WALK_LENGTH: walk_length_ff <= csr_if.data;
            REG_NODE_COUNT:  node_count_ff  <= csr_if.data[NODE_COUNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   mwc_ctrl #(
      .MAX_NODES (MAX_NODES),
      .MAX_EDGES (MAX_EDGES)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_if.valid),
      .req_cmd     (req_if.cmd),
      .req_target  (req_if.target_node),
      .req_source  (req_if.source_node),
      .req_ready   (req_if.ready),
      .walk_length (walk_length_ff),
      .node_count  (node_count_ff),
      .edge_rdata  (edge_rdata),
      .rsp_free    (rsp_free),
      .ctl         (ctl),
      .edge_waddr  (edge_waddr),
      .edge_raddr  (edge_raddr),
      .accept_addr (accept_addr),
      .prev_raddr  (prev_raddr),
      .next_raddr  (next_raddr),
      .row_waddr   (row_waddr),
      .status      (status),
      .done        (done)
   );

   mwc_store #(
      .MAX_NODES (MAX_NODES),
      .MAX_EDGES (MAX_EDGES)
   ) u_store (
      .clock        (clock),
      .ctl          (ctl),
      .edge_waddr   (edge_waddr),
      .edge_wdata   ({req_if.target_node, req_if.source_node}),
      .edge_raddr   (edge_raddr),
      .edge_rdata   (edge_rdata),
      .accept_addr  (accept_addr),
      .accept_rdata (accept_rdata),
      .prev_raddr   (prev_raddr),
      .next_raddr   (next_raddr),
      .row_waddr    (row_waddr),
      .row_wdata    (row_wdata),
      .prev_rdata   (prev_rdata),
      .next_rdata   (next_rdata)
   );

   // one adder serves both the edge accumulation and the final accept sum
   assign add_a = ctl.sum_phase ? sum_ff : next_rdata;
   assign add_b = (ctl.sum_phase && !accept_rdata) ? '0 : prev_rdata;

   mwc_mod_add u_mod_add (
      .op_a (add_a),
      .op_b (add_b),
      .sum  (add_sum)
   );

   always_comb begin
      if (ctl.row_wr_sum) begin
         row_wdata = add_sum;
      end else if (ctl.row_wr_one) begin
         row_wdata = COUNT_W'(1);
      end else begin
         row_wdata = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.sum_clr) begin
         sum_ff <= '0;
      end else if (ctl.sum_en) begin
         sum_ff <= add_sum;
      end
   end

   assign rsp_free = !rsp_valid_ff || rsp_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (done) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         rsp_count_ff  <= sum_ff;
         rsp_status_ff <= status;
      end
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.walk_count = rsp_count_ff;
   assign rsp_if.status     = rsp_status_ff;

endmodule

>>> sv/mwc_checker.sv
// Port-level checks of the modular walk counter, bound to the top level.
module mwc_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic [1:0]                    req_cmd,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [mwc_pkg::COUNT_W-1:0]   rsp_walk_count,
   input logic [mwc_pkg::STATUS_W-1:0]  rsp_status
);
   import mwc_pkg::*;

   // reset starts the accept sweep and empties the output stage
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !req_ready && !rsp_valid)
      else $error("busy or result pending right after reset");

   // a run or clear occupies the sequencer
   a_long_cmd_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_cmd == CMD_RUN || req_cmd == CMD_CLEAR)
      |=> !req_ready)
      else $error("request taken right after a run or clear");

   a_count_reduced: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_walk_count < WALK_MOD)
      else $error("walk count not reduced modulo the prime");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready
      |=> rsp_valid && $stable(rsp_walk_count) && $stable(rsp_status))
      else $error("stalled result dropped or changed");

endmodule

bind modular_walk_counter mwc_checker u_mwc_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_if.valid),
   .req_ready      (req_if.ready),
   .req_cmd        (req_if.cmd),
   .rsp_valid      (rsp_if.valid),
   .rsp_ready      (rsp_if.ready),
   .rsp_walk_count (rsp_if.walk_count),
   .rsp_status     (rsp_if.status)
);

>>> tb/sv/tb.sv
// Testbench for the modular walk counter: self-predicting scoreboard with randomized traffic.
`timescale 1ns / 100ps

module tb;
   import mwc_pkg::*;

   localparam int LIMIT_CYCLES  = 4_000_000;
   localparam int SETTLE_CYCLES = DEF_MAX_NODES + 64;
   localparam int HOLD_CYCLES   = 3000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   mwc_req_if req_ch ();
   mwc_rsp_if rsp_ch ();
   mwc_csr_if csr_ch ();

   modular_walk_counter u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch.sink),
      .rsp_if (rsp_ch.source),
      .csr_if (csr_ch.sink)
   );

   always #2 clock = ~clock;

   class walk_count_scoreboard_type;
      typedef struct {
         logic [COUNT_W-1:0]  walk_count;
         logic [STATUS_W-1:0] status;
      } walk_result_type;

      logic [WALK_LEN_W-1:0]   walk_length;
      logic [NODE_COUNT_W-1:0] node_count;
      logic [EDGE_W-1:0]       edges [DEF_MAX_EDGES];
      int unsigned             edge_total;
      bit                      accepting [DEF_MAX_NODES];
      logic [STATUS_W-1:0]     err_flags;
      walk_result_type         expected_counts [$];
      int                      mismatches;

      function new();
         walk_length = '0;
         node_count  = NODE_COUNT_W'(DEF_NODE_COUNT);
         edge_total  = 0;
         foreach (accepting[v]) accepting[v] = 1'b0;
         err_flags   = '0;
         mismatches  = 0;
      endfunction

      function void write_reg(reg_index_type idx, logic [CSR_DATA_W-1:0] value);
         if (idx == REG_WALK_LENGTH) walk_length = value[WALK_LEN_W-1:0];
         else node_count = value[NODE_COUNT_W-1:0];
      endfunction

      function int unsigned live_nodes();
         int unsigned n;
         n = node_count;
         if (n == 0) n = 1;
         if (n > DEF_MAX_NODES) n = DEF_MAX_NODES;
         return n;
      endfunction

      function int unsigned mod_sum(int unsigned a, int unsigned b);
         int unsigned s;
         s = a + b;
         return (s >= WALK_MOD) ? s - WALK_MOD : s;
      endfunction

      function logic [COUNT_W-1:0] count_walks();
         int unsigned n, dst, src, total, step;
         int unsigned row_prev [DEF_MAX_NODES];
         int unsigned row_next [DEF_MAX_NODES];
         n = live_nodes();
         for (int v = 0; v < n; v++) row_prev[v] = 0;
         row_prev[0] = 1;
         for (step = 1; step <= walk_length; step++) begin
            for (int v = 0; v < n; v++) row_next[v] = 0;
            for (int e = 0; e < edge_total; e++) begin
               dst = edges[e][EDGE_W-1:NODE_W];
               src = edges[e][NODE_W-1:0];
               // skip edges touching nodes beyond the current node count
               if (dst < n && src < n) row_next[dst] = mod_sum(row_next[dst], row_prev[src]);
            end
            for (int v = 0; v < n; v++) row_prev[v] = row_next[v];
         end
         total = 0;
         for (int v = 0; v < n; v++)
            if (accepting[v]) total = mod_sum(total, row_prev[v]);
         return COUNT_W'(total);
      endfunction

      function void note_request(cmd_type cmd, logic [NODE_W-1:0] tgt, logic [NODE_W-1:0] src);
         int unsigned     n;
         walk_result_type res;
         n = live_nodes();
         case (cmd)
            CMD_ADD_EDGE: begin
               if (tgt >= n || src >= n) err_flags[ERR_BAD_NODE] = 1'b1;
               else if (edge_total >= DEF_MAX_EDGES) err_flags[ERR_EDGE_FULL] = 1'b1;
               else begin
                  edges[edge_total] = {tgt, src};
                  edge_total++;
               end
            end
            CMD_MARK_ACCEPT: begin
               if (tgt >= n) err_flags[ERR_BAD_NODE] = 1'b1;
               else accepting[tgt] = 1'b1;
            end
            CMD_RUN: begin
               res.walk_count = count_walks();
               res.status     = err_flags;
               expected_counts.insert(expected_counts.size(), res);
            end
            CMD_CLEAR: begin
               // error flags stay sticky across a clear
               edge_total = 0;
               foreach (accepting[v]) accepting[v] = 1'b0;
            end
            default: ;
         endcase
      endfunction

      function void check_result(logic [COUNT_W-1:0] wc, logic [STATUS_W-1:0] st);
         walk_result_type want;
         if (expected_counts.size() == 0) begin
            $error("walk_count %0d status %0d arrived with no run pending", wc, st);
            mismatches++;
            return;
         end
         want = expected_counts.pop_front();
         if (wc !== want.walk_count) begin
            $error("walk_count: expected %0d, actual %0d", want.walk_count, wc);
            mismatches++;
         end
         if (st !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, st);
            mismatches++;
         end
      endfunction
   endclass

   walk_count_scoreboard_type board = new();

   int          req_idle_pct  = 0;
   int          rsp_stall_pct = 0;
   int          rsp_hold      = 0;
   int unsigned cycle_count;

   // response side: random stalls, or a long hold-off when requested
   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_ch.ready <= 1'b0;
         rsp_hold = rsp_hold - 1;
      end else begin
         rsp_ch.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         board.check_result(rsp_ch.walk_count, rsp_ch.status);
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   task automatic send_request(cmd_type cmd, logic [NODE_W-1:0] tgt, logic [NODE_W-1:0] src);
      int gap;
      gap = 0;
      while ($urandom_range(0, 99) < req_idle_pct) gap++;
      @(negedge clock);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.cmd         <= cmd;
      req_ch.target_node <= tgt;
      req_ch.source_node <= src;
      do @(posedge clock); while (!req_ch.ready);
      board.note_request(cmd, tgt, src);
   endtask

   task automatic write_reg(reg_index_type idx, logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      do @(posedge clock); while (!csr_ch.ready);
      board.write_reg(idx, value);
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   // drop the request, drain all runs, then give a trailing clear time to finish
   task automatic settle();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (board.expected_counts.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic random_request();
      int unsigned       n, r;
      logic [NODE_W-1:0] tgt, src;
      n   = board.live_nodes();
      r   = $urandom_range(0, 99);
      tgt = NODE_W'($urandom_range(0, n - 1));
      src = ($urandom_range(0, 3) == 0) ? '0 : NODE_W'($urandom_range(0, n - 1));
      // keep the edge store small so runs stay short
      if (board.edge_total > 40) send_request(CMD_CLEAR, tgt, src);
      else if (r < 45) send_request(CMD_ADD_EDGE, tgt, src);
      else if (r < 60) send_request(CMD_MARK_ACCEPT, tgt, src);
      else if (r < 72) send_request(CMD_RUN, tgt, src);
      else if (r < 75) send_request(CMD_CLEAR, tgt, src);
      else send_request(cmd_type'($urandom_range(0, 3)), NODE_W'($urandom_range(0, 255)),
                        NODE_W'($urandom_range(0, 255)));
   endtask

   task automatic random_phase(int idle_pct, int stall_pct, int count,
                               logic [CSR_DATA_W-1:0] len, logic [CSR_DATA_W-1:0] nodes);
      settle();
      write_reg(REG_WALK_LENGTH, len);
      write_reg(REG_NODE_COUNT, nodes);
      req_idle_pct  = idle_pct;
      rsp_stall_pct = stall_pct;
      repeat (count) random_request();
   endtask

   initial begin
      req_ch.valid       = 1'b0;
      req_ch.cmd         = CMD_ADD_EDGE;
      req_ch.target_node = '0;
      req_ch.source_node = '0;
      rsp_ch.ready       = 1'b0;
      csr_ch.valid       = 1'b0;
      csr_ch.index       = REG_WALK_LENGTH;
      csr_ch.data        = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // zero walk length: answer follows whether node 0 accepts
      send_request(CMD_RUN, 8'd0, 8'd0);
      send_request(CMD_MARK_ACCEPT, 8'd0, 8'd0);
      send_request(CMD_RUN, 8'd0, 8'd0);

      settle();
      write_reg(REG_WALK_LENGTH, 16'd2);
      write_reg(REG_NODE_COUNT, 16'd256);
      send_request(CMD_ADD_EDGE, 8'd1, 8'd0);
      send_request(CMD_ADD_EDGE, 8'd1, 8'd0);
      send_request(CMD_ADD_EDGE, 8'd255, 8'd1);
      send_request(CMD_ADD_EDGE, 8'd0, 8'd255);
      send_request(CMD_MARK_ACCEPT, 8'd255, 8'd0);
      send_request(CMD_MARK_ACCEPT, 8'd255, 8'd0);
      send_request(CMD_RUN, 8'd0, 8'd0);

      // shrink the graph under stored edges, then hit bad node indices
      settle();
      write_reg(REG_NODE_COUNT, 16'd4);
      send_request(CMD_RUN, 8'd0, 8'd0);
      send_request(CMD_ADD_EDGE, 8'd200, 8'd0);
      send_request(CMD_MARK_ACCEPT, 8'd4, 8'd0);
      send_request(CMD_RUN, 8'd0, 8'd0);
      send_request(CMD_CLEAR, 8'd0, 8'd0);
      send_request(CMD_RUN, 8'd0, 8'd0);

      // node count zero acts as one node; longest walk over doubled self loops
      settle();
      write_reg(REG_NODE_COUNT, 16'hFE00);
      write_reg(REG_WALK_LENGTH, 16'hFFFF);
      send_request(CMD_ADD_EDGE, 8'd0, 8'd0);
      send_request(CMD_ADD_EDGE, 8'd0, 8'd0);
      send_request(CMD_MARK_ACCEPT, 8'd0, 8'd0);
      send_request(CMD_RUN, 8'd0, 8'd0);

      random_phase(0, 0, 260, 16'd3, 16'd6);
      // hold the response side while requests keep coming
      rsp_hold = HOLD_CYCLES;
      repeat (40) random_request();
      random_phase(50, 0, 260, CSR_DATA_W'($urandom_range(0, 10)), 16'hFFFF);
      random_phase(0, 50, 260, CSR_DATA_W'($urandom_range(0, 10)),
                   {7'($urandom_range(0, 127)), 9'($urandom_range(1, 16))});
      random_phase(25, 25, 260, 16'd5, 16'd12);
      settle();

      if (board.mismatches == 0 && board.expected_counts.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
